/* hdl/lva_pkg.sv */
// Shared types, constants and helpers for the LRU voice allocator.
// No dependencies; every other file in hdl/ imports this package.
package lva_pkg;

  localparam int MAX_VOICES  = 32;
  localparam int VOICE_W     = $clog2(MAX_VOICES);
  localparam int COUNT_W     = VOICE_W + 1;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = COUNT_W;

  typedef logic [VOICE_W-1:0] voice_t;
  typedef logic [COUNT_W-1:0] count_t;

  localparam logic [CFG_INDEX_W-1:0] REG_VOICE_COUNT = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ENABLE      = 1'd1;

  localparam logic CMD_PLAY    = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  localparam count_t VOICE_COUNT_RESET = count_t'(8);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic   en;
    logic   play;
    voice_t voice;
    logic   want_loop;
  } commit_t;

  typedef struct packed {
    logic   done;
    logic   found;
    logic   stolen;
    voice_t pick;
  } scan_status_t;

  function automatic count_t active_count(input count_t c);
    active_count = (c > count_t'(MAX_VOICES)) ? count_t'(MAX_VOICES) : c;
  endfunction

endpackage

/* hdl/lva_voice_regs.sv */
// Per-voice busy marks, loop marks and recency ranks, with the commit update.
// Depends on lva_pkg.
module lva_voice_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          rank_reset,
  input  lva_pkg::commit_t              cmt,
  input  lva_pkg::count_t               n,
  input  lva_pkg::voice_t               rd_idx,
  output logic [lva_pkg::MAX_VOICES-1:0] busy,
  output logic [lva_pkg::MAX_VOICES-1:0] looping,
  output lva_pkg::voice_t               rank_rd
);
  import lva_pkg::*;

  voice_t rank [MAX_VOICES];
  voice_t old_rank;
  count_t n_m1;
  voice_t top_rank;

  assign rank_rd  = rank[rd_idx];
  assign old_rank = rank[cmt.voice];
  assign n_m1     = n - count_t'(1);
  assign top_rank = n_m1[VOICE_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= '0;
      looping <= '0;
      for (int v = 0; v < MAX_VOICES; v++) begin
        rank[v] <= voice_t'(v);
      end
    end else if (rank_reset) begin
      for (int v = 0; v < MAX_VOICES; v++) begin
        rank[v] <= voice_t'(v);
      end
    end else if (cmt.en) begin
      if (cmt.play) begin
        busy[cmt.voice]    <= 1'b1;
        looping[cmt.voice] <= cmt.want_loop;
        for (int v = 0; v < MAX_VOICES; v++) begin
          if (count_t'(v) < n) begin
            if (voice_t'(v) == cmt.voice) begin
              rank[v] <= top_rank;
            end else if (rank[v] >= old_rank) begin
              rank[v] <= rank[v] - voice_t'(1);
            end
          end
        end
      end else begin
        busy[cmt.voice]    <= 1'b0;
        looping[cmt.voice] <= 1'b0;
      end
    end
  end

endmodule

/* hdl/lva_scan.sv */
// Voice scanner: steps through one voice per cycle with a shared rank compare,
// stopping at the first free voice or tracking the oldest stealable one. Uses lva_pkg.
module lva_scan (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  lva_pkg::count_t               n,
  input  logic [lva_pkg::MAX_VOICES-1:0] busy,
  input  logic [lva_pkg::MAX_VOICES-1:0] looping,
  input  lva_pkg::voice_t               rank_rd,
  output lva_pkg::voice_t               idx,
  output lva_pkg::scan_status_t         status
);
  import lva_pkg::*;

  logic   active;
  logic   done;
  logic   found;
  logic   stolen;
  voice_t pick;
  voice_t best;
  logic   last;
  logic   better;

  assign last   = (count_t'(idx) == (n - count_t'(1)));
  assign better = !looping[idx] && (!found || (rank_rd < best));

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      found  <= 1'b0;
      stolen <= 1'b0;
      idx    <= '0;
    end else if (start) begin
      active <= 1'b1;
      done   <= 1'b0;
      found  <= 1'b0;
      stolen <= 1'b0;
      idx    <= '0;
    end else if (active) begin
      if (!busy[idx]) begin
        pick   <= idx;
        found  <= 1'b1;
        stolen <= 1'b0;
        active <= 1'b0;
        done   <= 1'b1;
      end else begin
        if (better) begin
          pick   <= idx;
          best   <= rank_rd;
          found  <= 1'b1;
          stolen <= 1'b1;
        end
        if (last) begin
          active <= 1'b0;
          done   <= 1'b1;
        end else begin
          idx <= idx + voice_t'(1);
        end
      end
    end
  end

  assign status.done   = done;
  assign status.found  = found;
  assign status.stolen = stolen;
  assign status.pick   = pick;

endmodule

/* hdl/lru_voice_allocator_top.sv */
// Top level of the LRU voice allocator: configuration, control sequencer and result register.
// Depends on lva_pkg, lva_voice_regs and lva_scan.
//
// Usage: a request is a transfer on the input channel (command, voice_index,
// want_loop, has_data); every request yields exactly one transfer on the output
// channel (granted, voice, stolen). Configuration writes go through cfg_write,
// cfg_index and cfg_data and take effect at the same edge; they are to be made
// only while the block is idle, which the user must ensure: the block itself does
// not enforce it. Writing voice_count puts every rank back to its voice index.
// A release, or a play request that fails before scanning, goes from the idle state
// to the commit state and then into the result register. A play request that scans
// passes through the scan state, which stops at the first free voice or after the
// last voice in effect, then the commit state. The scan examines one voice per cycle
// through a single rank comparator. One request is handled at a time: in_ready is
// high only while the sequencer is idle, so a request is taken only after the last
// one is committed. A new request may be taken while a result still waits in the output
// register. When the receiver stalls, the next result and its state update wait until
// the output register is free. Reset clears all busy and loop marks, sets the ranks to
// the voice index, voice_count to 8 and enable to 0.
module lru_voice_allocator_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [lva_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [lva_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              command,
  input  lva_pkg::voice_t                   voice_index,
  input  logic                              want_loop,
  input  logic                              has_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              granted,
  output lva_pkg::voice_t                   voice,
  output logic                              stolen
);
  import lva_pkg::*;

  state_t          state;
  state_t          state_next;
  count_t          voice_count;
  logic            enable;
  count_t          n;
  logic            rank_reset;
  logic            in_xfer;
  logic            play_go;
  logic            scan_start;
  logic            slot_free;
  logic            cmt_go;
  logic            cmd_q;
  voice_t          vidx_q;
  logic            loop_q;
  logic            go_q;
  logic            rel_ok;
  logic            res_grant;
  logic            res_stolen;
  commit_t         cmt;
  scan_status_t    scan_status;
  voice_t          scan_idx;
  voice_t          rank_rd;
  logic [MAX_VOICES-1:0] busy;
  logic [MAX_VOICES-1:0] looping;

  assign n          = active_count(voice_count);
  assign rank_reset = cfg_write && (cfg_index == REG_VOICE_COUNT);
  assign in_xfer    = in_valid && in_ready;
  assign play_go    = enable && (n != '0) && has_data;
  assign scan_start = in_xfer && (command == CMD_PLAY) && play_go;
  assign slot_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      voice_count <= VOICE_COUNT_RESET;
      enable      <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_VOICE_COUNT: voice_count <= cfg_data[COUNT_W-1:0];
        REG_ENABLE:      enable      <= cfg_data[0];
        default:         ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cmd_q  <= command;
      vidx_q <= voice_index;
      loop_q <= want_loop;
      go_q   <= play_go;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (scan_start) begin
          state_next = ST_SCAN;
        end else if (in_xfer) begin
          state_next = ST_COMMIT;
        end
      end
      ST_SCAN: begin
        if (scan_status.done) begin
          state_next = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmt_go   = 1'b0;
    case (state)
      ST_IDLE:   in_ready = 1'b1;
      ST_COMMIT: cmt_go   = slot_free;
      default:   ;
    endcase
  end

  assign rel_ok = (count_t'(vidx_q) < n) && busy[vidx_q];

  always_comb begin
    cmt.want_loop = loop_q;
    if (cmd_q == CMD_RELEASE) begin
      res_grant  = rel_ok;
      res_stolen = 1'b0;
      cmt.play   = 1'b0;
      cmt.voice  = vidx_q;
    end else begin
      res_grant  = go_q && scan_status.found;
      res_stolen = scan_status.stolen;
      cmt.play   = 1'b1;
      cmt.voice  = scan_status.pick;
    end
    cmt.en = cmt_go && res_grant;
  end

  lva_voice_regs u_regs (
    .clk        (clk),
    .rst        (rst),
    .rank_reset (rank_reset),
    .cmt        (cmt),
    .n          (n),
    .rd_idx     (scan_idx),
    .busy       (busy),
    .looping    (looping),
    .rank_rd    (rank_rd)
  );

  lva_scan u_scan (
    .clk     (clk),
    .rst     (rst),
    .start   (scan_start),
    .n       (n),
    .busy    (busy),
    .looping (looping),
    .rank_rd (rank_rd),
    .idx     (scan_idx),
    .status  (scan_status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmt_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmt_go) begin
      granted <= res_grant;
      voice   <= res_grant ? cmt.voice : '0;
      stolen  <= res_grant && res_stolen;
    end
  end

  a_grant_busy: assert property (@(posedge clk) disable iff (rst)
    (cmt.en && cmt.play) |=> busy[$past(cmt.voice)])
    else $error("Granted voice is not marked busy after the commit.");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !granted) |-> ((voice == '0) && !stolen))
    else $error("A refused request carries a nonzero voice or steal mark.");

  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (count_t'(scan_idx) < n))
    else $error("Scan index runs past the voice count in effect.");

  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !in_xfer)
    else $error("A request transfer happened while the sequencer was busy.");

endmodule
